// ----- hw/rtl/u8s_pkg.sv -----
`timescale 1ns / 1ps

package u8s_pkg;

   // Bytes of the inserted U+FFFD replacement, in output order.
   localparam logic [7:0] REPL_BYTE0 = 8'hEF;
   localparam logic [7:0] REPL_BYTE1 = 8'hBF;
   localparam logic [7:0] REPL_BYTE2 = 8'hBD;

   // Code point limits used by the sequence check.
   localparam logic [20:0] MIN_CP2  = 21'h000080;
   localparam logic [20:0] MIN_CP3  = 21'h000800;
   localparam logic [20:0] MIN_CP4  = 21'h010000;
   localparam logic [20:0] SURR_LO  = 21'h00D800;
   localparam logic [20:0] SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] CP_MAX   = 21'h10FFFF;

   // Depth of the request queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Sequence length implied by a lead byte, 0 when the byte cannot lead.
   typedef logic [2:0] seq_len_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic [7:0]  data;
      logic        at_end;
      seq_len_type len;
      logic        cont;
   } item_type;

   // Classification of a single byte as a sequence lead.
   function automatic seq_len_type lead_len(input logic [7:0] b);
      seq_len_type len;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

endpackage

// ----- hw/rtl/u8s_if.sv -----
`timescale 1ns / 1ps

// Request channel: one raw byte per request.
interface u8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Result channel: one sanitized byte per result.
interface u8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_replacement;
   logic       last_of_run;
   logic       end_of_output;

   modport source (output valid, output out_byte, output is_replacement,
                   output last_of_run, output end_of_output, input ready);
   modport sink (input valid, input out_byte, input is_replacement,
                 input last_of_run, input end_of_output, output ready);
endinterface

// ----- hw/rtl/u8s_front.sv -----
`timescale 1ns / 1ps

module u8s_front
   import u8s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8s_req_if.sink     req_chan,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic                     push;
   logic                     pop;
   item_type                 new_item;

   // Classify the incoming byte so the back can scan without decoding leads.
   always_comb begin
      new_item.data   = req_chan.in_byte;
      new_item.at_end = req_chan.end_of_input;
      new_item.len    = lead_len(req_chan.in_byte);
      new_item.cont   = (req_chan.in_byte[7:6] == 2'b10);
   end

   assign req_chan.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign q_valid        = (count_ff != '0);
   assign q_item         = entry_ff[rd_ptr_ff];
   assign pop            = q_pop && q_valid;

   // Pointer and fill count of the request queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hw/rtl/u8s_back.sv -----
`timescale 1ns / 1ps

module u8s_back
   import u8s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   u8s_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_COPY,
      ST_REPL
   } state_type;

   state_type     state_ff;
   logic [7:0]    byte_ff [4];
   seq_len_type   len_ff  [4];
   logic          cont_ff [4];
   logic [2:0]    n_ff;
   logic          at_end_ff;
   logic [2:0]    cnt_ff;
   logic [1:0]    phase_ff;
   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          out_repl_ff;
   logic          out_last_ff;
   logic          out_eoo_ff;

   logic          out_free;
   logic          emit;
   logic          must_wait;
   logic          seq_fits;
   logic          seq_ok;
   logic [2:0]    n_after;
   logic          stop_after;
   logic [20:0]   cp;
   logic [7:0]    repl_byte;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = out_free && ((state_ff == ST_COPY) || (state_ff == ST_REPL));
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   // Decision on the sequence that starts at the oldest held byte.
   assign must_wait = (len_ff[0] != 3'd0) && (len_ff[0] > n_ff) && !at_end_ff;
   assign seq_fits  = (len_ff[0] != 3'd0) && (len_ff[0] <= n_ff);

   always_comb begin
      cp     = '0;
      seq_ok = 1'b0;
      unique case (len_ff[0])
         3'd1: begin
            seq_ok = 1'b1;
         end
         3'd2: begin
            cp     = {10'd0, byte_ff[0][4:0], byte_ff[1][5:0]};
            seq_ok = cont_ff[1] && (cp >= MIN_CP2);
         end
         3'd3: begin
            cp     = {5'd0, byte_ff[0][3:0], byte_ff[1][5:0], byte_ff[2][5:0]};
            seq_ok = cont_ff[1] && cont_ff[2] && (cp >= MIN_CP3)
                     && !((cp >= SURR_LO) && (cp <= SURR_HI));
         end
         3'd4: begin
            cp     = {byte_ff[0][2:0], byte_ff[1][5:0], byte_ff[2][5:0], byte_ff[3][5:0]};
            seq_ok = cont_ff[1] && cont_ff[2] && cont_ff[3]
                     && (cp >= MIN_CP4) && (cp <= CP_MAX);
         end
         default: begin
            seq_ok = 1'b0;
         end
      endcase
   end

   // After one byte is dropped, tells whether the scan stops for this request.
   assign n_after    = n_ff - 3'd1;
   assign stop_after = (n_after == 3'd0)
                       || (!at_end_ff && (len_ff[1] != 3'd0) && (len_ff[1] > n_after));

   always_comb begin
      unique case (phase_ff)
         2'd0:    repl_byte = REPL_BYTE0;
         2'd1:    repl_byte = REPL_BYTE1;
         default: repl_byte = REPL_BYTE2;
      endcase
   end

   // Scan sequencer with the held bytes and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // A new result loads when the register is free; a taken result clears it.
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  byte_ff[n_ff[1:0]] <= q_item.data;
                  len_ff[n_ff[1:0]]  <= q_item.len;
                  cont_ff[n_ff[1:0]] <= q_item.cont;
                  at_end_ff          <= q_item.at_end;
                  n_ff               <= n_ff + 3'd1;
                  state_ff           <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if ((n_ff == 3'd0) || must_wait) begin
                  state_ff <= ST_IDLE;
               end else if (seq_fits && seq_ok) begin
                  cnt_ff   <= len_ff[0];
                  state_ff <= ST_COPY;
               end else begin
                  phase_ff <= 2'd0;
                  state_ff <= ST_REPL;
               end
            end
            ST_COPY: begin
               if (out_free) begin
                  out_byte_ff  <= byte_ff[0];
                  out_repl_ff  <= 1'b0;
                  out_last_ff  <= (cnt_ff == 3'd1) && stop_after;
                  out_eoo_ff   <= (cnt_ff == 3'd1) && stop_after && at_end_ff;
                  for (int i = 0; i < 3; i++) begin
                     byte_ff[i] <= byte_ff[i+1];
                     len_ff[i]  <= len_ff[i+1];
                     cont_ff[i] <= cont_ff[i+1];
                  end
                  n_ff   <= n_after;
                  cnt_ff <= cnt_ff - 3'd1;
                  if (cnt_ff == 3'd1) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_REPL: begin
               if (out_free) begin
                  out_byte_ff  <= repl_byte;
                  out_repl_ff  <= 1'b1;
                  out_last_ff  <= (phase_ff == 2'd2) && stop_after;
                  out_eoo_ff   <= (phase_ff == 2'd2) && stop_after && at_end_ff;
                  phase_ff     <= phase_ff + 2'd1;
                  // The lead byte goes with the last replacement byte.
                  if (phase_ff == 2'd2) begin
                     for (int i = 0; i < 3; i++) begin
                        byte_ff[i] <= byte_ff[i+1];
                        len_ff[i]  <= len_ff[i+1];
                        cont_ff[i] <= cont_ff[i+1];
                     end
                     n_ff     <= n_after;
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_byte       = out_byte_ff;
   assign rsp_chan.is_replacement = out_repl_ff;
   assign rsp_chan.last_of_run    = out_last_ff;
   assign rsp_chan.end_of_output  = out_eoo_ff;

endmodule

// ----- hw/rtl/utf8_sanitizer_unit.sv -----
`timescale 1ns / 1ps

// UTF-8 sanitizer. Requests arrive on req_chan, one raw byte each with an
// end-of-input flag; sanitized bytes leave on rsp_chan, one per result.
// Well-formed sequences pass through unchanged; each invalid lead byte is
// replaced by EF BF BD and the bytes after it are scanned again.
// The front classifies each byte and places it in a two-entry queue, so a
// new request is taken while the back is still scanning or stalled.
// The back loads a byte in ST_IDLE, decides on the held sequence in
// ST_DECIDE and sends output bytes from ST_COPY or ST_REPL. A request that
// leaves its byte held gives no result. Reset clears the queue, the held
// byte count and the result valid flag; the held bytes and the result byte
// are not cleared. When the receiver holds ready low, the result register
// keeps its byte, the back stops, and the queue fills and then drops
// req_chan.ready.
module utf8_sanitizer_unit
   import u8s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u8s_req_if.sink     req_chan,
   u8s_rsp_if.source   rsp_chan
);

   logic       q_valid;
   item_type   q_item;
   logic       q_pop;

   u8s_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   u8s_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
